// ===== rtl/deq_pkg.sv =====
package deq_pkg;

	// operation codes carried on the action port
	localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [1:0] ACT_PUSH_REAR  = 2'd1;
	localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [1:0] ACT_POP_REAR   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// fixed port widths
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int OCC_W    = 5;

	typedef enum logic [0:0] {
		CTL_IDLE,
		CTL_RESP
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;     // request accepted this cycle, run the operation
		logic respond;  // result cycle, drive the result ports
	} deq_cmd_t;

endpackage

// ===== rtl/deq_ram.sv =====
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output deq_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (start) begin
					state_n = CTL_RESP;
				end
			end
			CTL_RESP: begin
				state_n = CTL_IDLE;
			end
			default: begin
				state_n = CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		done        = 1'b0;
		cmd.exec    = 1'b0;
		cmd.respond = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				cmd.exec = start;
			end
			CTL_RESP: begin
				busy        = 1'b1;
				done        = 1'b1;
				cmd.respond = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	property p_resp_one_cycle;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_resp_one_cycle: assert property (p_resp_one_cycle)
		else $error("result strobe held for more than one cycle");

	property p_start_gives_result;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> done;
	endproperty
	a_start_gives_result: assert property (p_start_gives_result)
		else $error("accepted request gave no result in the next cycle");

endmodule

// ===== rtl/deq_dpath.sv =====
module deq_dpath
	import deq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_cmd_t                   cmd,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [VALUE_W-1:0]  value,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  popped,
	output logic [OCC_W-1:0]           occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [STATUS_W-1:0] status_q;
	logic                pop_q;

	logic [IDX_W-1:0]    head_n;
	logic [CNT_W-1:0]    count_n;
	logic [STATUS_W-1:0] status_n;
	logic                pop_n;

	logic                full;
	logic                empty;
	logic [IDX_W-1:0]    head_dec;
	logic [IDX_W-1:0]    head_inc;
	logic [CNT_W-1:0]    rear_off;
	logic [SUM_W-1:0]    rear_sum;
	logic [SUM_W-1:0]    rear_wrap;
	logic [IDX_W-1:0]    rear_slot;

	logic                ram_we;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_addr;
	logic [ITEM_BITS-1:0] ram_wdata;
	logic [ITEM_BITS-1:0] ram_rdata;

	logic [VALUE_W+ITEM_BITS-1:0] value_ext;
	logic [ITEM_BITS+VALUE_W-1:0] rdata_ext;
	logic [CNT_W+OCC_W-1:0]       count_ext;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// ring neighbors of the head, wrapping at any depth
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	// rear push goes one past the last entry, rear pop takes the last entry
	assign rear_off  = (action == ACT_PUSH_REAR) ? count_q : count_q - 1'b1;
	assign rear_sum  = SUM_W'(head_q) + SUM_W'(rear_off);
	assign rear_wrap = (rear_sum >= SUM_W'(DEPTH)) ? rear_sum - SUM_W'(DEPTH) : rear_sum;
	assign rear_slot = rear_wrap[IDX_W-1:0];

	assign value_ext = {{ITEM_BITS{1'b0}}, value};
	assign ram_wdata = value_ext[ITEM_BITS-1:0];

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		status_n = ST_OK;
		pop_n    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = head_q;
		if (cmd.exec) begin
			unique case (action)
				ACT_PUSH_FRONT: begin
					if (full) begin
						status_n = ST_FULL;
					end else begin
						ram_we   = 1'b1;
						ram_addr = head_dec;
						head_n   = head_dec;
						count_n  = count_q + 1'b1;
					end
				end
				ACT_PUSH_REAR: begin
					if (full) begin
						status_n = ST_FULL;
					end else begin
						ram_we   = 1'b1;
						ram_addr = rear_slot;
						count_n  = count_q + 1'b1;
					end
				end
				ACT_POP_FRONT: begin
					if (empty) begin
						status_n = ST_EMPTY;
					end else begin
						ram_re   = 1'b1;
						ram_addr = head_q;
						pop_n    = 1'b1;
						head_n   = head_inc;
						count_n  = count_q - 1'b1;
					end
				end
				ACT_POP_REAR: begin
					if (empty) begin
						status_n = ST_EMPTY;
					end else begin
						ram_re   = 1'b1;
						ram_addr = rear_slot;
						pop_n    = 1'b1;
						count_n  = count_q - 1'b1;
					end
				end
				default: begin
					status_n = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			pop_q    <= 1'b0;
			status_q <= ST_OK;
		end else if (cmd.exec) begin
			head_q   <= head_n;
			count_q  <= count_n;
			pop_q    <= pop_n;
			status_q <= status_n;
		end
	end

	deq_ram #(
		.WIDTH (ITEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rdata_ext = {{VALUE_W{ram_rdata[ITEM_BITS-1]}}, ram_rdata};
	assign count_ext = {{OCC_W{1'b0}}, count_q};

	assign status    = cmd.respond ? status_q : ST_OK;
	assign popped    = (cmd.respond && pop_q) ? signed'(rdata_ext[VALUE_W-1:0]) : '0;
	assign occupancy = count_ext[OCC_W-1:0];

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("entry count beyond depth");

	property p_head_bound;
		@(posedge clk) disable iff (!arst_n) head_q <= IDX_W'(DEPTH - 1);
	endproperty
	a_head_bound: assert property (p_head_bound)
		else $error("head index beyond ring");

	property p_full_status;
		@(posedge clk) disable iff (!arst_n)
			(cmd.respond && status_q == ST_FULL) |-> full;
	endproperty
	a_full_status: assert property (p_full_status)
		else $error("full status with room left");

	property p_empty_status;
		@(posedge clk) disable iff (!arst_n)
			(cmd.respond && status_q == ST_EMPTY) |-> empty && !pop_q;
	endproperty
	a_empty_status: assert property (p_empty_status)
		else $error("empty status with entries held");

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// channel   direction  handshake               payload
// request   in         start & !busy           action, value
// result    out        done, one cycle only    status, popped, occupancy
//
// the ring is read or written in the cycle a request is accepted, and the result
// shows in the next cycle while the ram read data lands.
// busy is high during the result cycle, so no new request is taken until it is over.
// reset clears head index, count and controller; ring contents stay undefined.
// the receiver cannot stall; a result is on the ports for one cycle only.
module double_ended_queue_core
	import deq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  popped,
	output logic [OCC_W-1:0]           occupancy
);

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	deq_dpath #(
		.DEPTH     (DEPTH),
		.ITEM_BITS (ITEM_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (action),
		.value     (value),
		.status    (status),
		.popped    (popped),
		.occupancy (occupancy)
	);

endmodule
